// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/pss_pkg.sv =====
// ---------------------------------------------------------------------------
// pss_pkg
// shared codes, reset values and controller/datapath interface types
// ---------------------------------------------------------------------------
package pss_pkg;

  localparam int WAIT_DEPTH_DEF = 8;
  localparam int MAX_RESULTS    = 8;

  localparam logic [7:0]  CAP_RESET   = 8'd4;
  localparam logic [15:0] LIMIT_RESET = 16'd50;

  // configuration register indexes
  localparam logic REG_CAP   = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    CMD_ARRIVE = 2'd0,
    CMD_LEAVE  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_GRANTED     = 3'd0,
    EV_QUEUED      = 3'd1,
    EV_HANDED      = 3'd2,
    EV_TIMED_OUT   = 3'd3,
    EV_LIST_FULL   = 3'd4,
    EV_LEAVE_DONE  = 3'd5,
    EV_LEAVE_EMPTY = 3'd6
  } event_t;

  typedef struct packed {
    logic latch;
    logic do_arrive;
    logic do_leave;
    logic do_age;
    logic do_give;
    logic do_expire;
    logic idx_clr;
    logic idx_inc;
    logic pick_load;
  } pss_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic held_zero;
    logic handover_ok;
    logic idx_in_range;
    logic idx_prio;
    logic idx_last;
    logic idx_exp;
    logic expire_last;
    logic res_full;
    logic out_free;
  } pss_sts_t;

endpackage

// ===== hw/rtl/pss_ctrl.sv =====
// ---------------------------------------------------------------------------
// pss_ctrl
// sequencer: accepts one beat, then steps the datapath through the
// arrive, leave/handover or tick/expire flow
// ---------------------------------------------------------------------------
module pss_ctrl
  import pss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pss_sts_t sts,
  output pss_cmd_t ctl
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_GIVE,
    ST_EXPIRE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          ctl.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.cmd)
          CMD_ARRIVE: begin
            if (sts.out_free) begin
              ctl.do_arrive = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          CMD_LEAVE: begin
            if (sts.out_free) begin
              ctl.do_leave = 1'b1;
              ctl.idx_clr  = 1'b1;
              state_nxt    = (!sts.held_zero && sts.handover_ok) ? ST_SCAN : ST_IDLE;
            end
          end
          CMD_TICK: begin
            ctl.do_age  = 1'b1;
            ctl.idx_clr = 1'b1;
            state_nxt   = ST_EXPIRE;
          end
          CMD_NONE: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        // oldest priority waiter, else the head of the list
        if (sts.idx_prio || sts.idx_last) begin
          ctl.pick_load = 1'b1;
          state_nxt     = ST_GIVE;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      ST_GIVE: begin
        if (sts.out_free) begin
          ctl.do_give = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_EXPIRE: begin
        priority if (!sts.idx_in_range || sts.res_full) begin
          state_nxt = ST_IDLE;
        end else if (sts.idx_exp) begin
          if (sts.out_free) begin
            ctl.do_expire = 1'b1;
            if (sts.expire_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== hw/rtl/pss_dpath.sv =====
// ---------------------------------------------------------------------------
// pss_dpath
// slot counter, ordered wait list with ages, scan pointer and result register
// ---------------------------------------------------------------------------
module pss_dpath
  import pss_pkg::*;
#(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pss_cmd_t    ctl,
  output pss_sts_t    sts,
  input  logic [1:0]  in_command,
  input  logic        in_is_priority,
  input  logic [7:0]  in_requester_id,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_who_id,
  output logic        out_who_priority,
  output logic [7:0]  out_held_count,
  output logic        out_last
);

  localparam int IDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_FILL = CNT_W'(WAIT_DEPTH);
  localparam logic [3:0]       RES_MAX   = 4'(MAX_RESULTS);

  logic [7:0]       cap_r;
  logic [15:0]      limit_r;
  logic [7:0]       held_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] idx_r;
  logic [IDX_W-1:0] pick_r;
  logic [3:0]       nres_r;
  cmd_t             cmd_r;
  logic             ipri_r;
  logic [7:0]       iid_r;

  logic        prio_r [WAIT_DEPTH];
  logic [7:0]  id_r   [WAIT_DEPTH];
  logic [15:0] age_r  [WAIT_DEPTH];
  logic        exp_r  [WAIT_DEPTH];

  logic        prio_up [WAIT_DEPTH];
  logic [7:0]  id_up   [WAIT_DEPTH];
  logic [15:0] age_up  [WAIT_DEPTH];
  logic        exp_up  [WAIT_DEPTH];
  logic [15:0] age_inc [WAIT_DEPTH];

  logic             out_valid_r;
  event_t           ev_r;
  logic [7:0]       who_id_r;
  logic             who_pri_r;
  logic [7:0]       held_out_r;
  logic             last_r;

  logic             out_free;
  logic             grant;
  logic             append;
  logic             remove;
  logic             handover_ok;
  logic             exp_after;
  logic             expire_last;
  logic             in_range;
  logic [IDX_W-1:0] idx_sel;
  logic [CNT_W-1:0] rem_pos;
  logic [7:0]       held_dec;
  logic [15:0]      lim_eff;

  logic             emit;
  event_t           ev_nxt;
  logic [7:0]       who_id_nxt;
  logic             who_pri_nxt;
  logic [7:0]       held_out_nxt;
  logic             last_nxt;

  // entry i takes entry i+1 when it or an entry below it leaves the list
  for (genvar g = 0; g < WAIT_DEPTH; g++) begin : g_up
    if (g < WAIT_DEPTH - 1) begin : g_mid
      assign prio_up[g] = prio_r[g+1];
      assign id_up[g]   = id_r[g+1];
      assign age_up[g]  = age_r[g+1];
      assign exp_up[g]  = exp_r[g+1];
    end else begin : g_top
      assign prio_up[g] = prio_r[g];
      assign id_up[g]   = id_r[g];
      assign age_up[g]  = age_r[g];
      assign exp_up[g]  = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      age_inc[i] = (age_r[i] == 16'hFFFF) ? age_r[i] : age_r[i] + 16'd1;
    end
  end

  // any expired waiter still queued behind the scan point
  always_comb begin
    exp_after = 1'b0;
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      if (CNT_W'(i) > idx_r && CNT_W'(i) < fill_r && exp_r[i]) begin
        exp_after = 1'b1;
      end
    end
  end

  assign lim_eff     = (limit_r == 16'd0) ? 16'd1 : limit_r;
  assign out_free    = !out_valid_r || out_ready;
  assign held_dec    = held_r - 8'd1;
  assign grant       = held_r < cap_r;
  assign append      = ctl.do_arrive && !grant && (fill_r != FULL_FILL);
  assign remove      = ctl.do_give || ctl.do_expire;
  assign rem_pos     = ctl.do_give ? CNT_W'(pick_r) : idx_r;
  assign handover_ok = (fill_r != '0) && (held_dec < cap_r);
  assign idx_sel     = idx_r[IDX_W-1:0];
  assign in_range    = idx_r < fill_r;
  assign expire_last = (nres_r == RES_MAX - 4'd1) || !exp_after;

  always_comb begin
    sts              = '0;
    sts.cmd          = cmd_r;
    sts.held_zero    = (held_r == 8'd0);
    sts.handover_ok  = handover_ok;
    sts.idx_in_range = in_range;
    sts.idx_prio     = in_range && prio_r[idx_sel];
    sts.idx_last     = (idx_r == fill_r - CNT_W'(1));
    sts.idx_exp      = in_range && exp_r[idx_sel];
    sts.expire_last  = expire_last;
    sts.res_full     = (nres_r == RES_MAX);
    sts.out_free     = out_free;
  end

  // result beat selection
  always_comb begin
    emit         = 1'b0;
    ev_nxt       = EV_GRANTED;
    who_id_nxt   = iid_r;
    who_pri_nxt  = ipri_r;
    held_out_nxt = held_r;
    last_nxt     = 1'b1;
    priority if (ctl.do_arrive) begin
      emit = 1'b1;
      priority if (grant) begin
        ev_nxt       = EV_GRANTED;
        held_out_nxt = held_r + 8'd1;
      end else if (fill_r != FULL_FILL) begin
        ev_nxt = EV_QUEUED;
      end else begin
        ev_nxt = EV_LIST_FULL;
      end
    end else if (ctl.do_leave) begin
      emit        = 1'b1;
      who_id_nxt  = 8'd0;
      who_pri_nxt = 1'b0;
      if (held_r == 8'd0) begin
        ev_nxt = EV_LEAVE_EMPTY;
      end else begin
        ev_nxt       = EV_LEAVE_DONE;
        held_out_nxt = held_dec;
        last_nxt     = !handover_ok;
      end
    end else if (ctl.do_give) begin
      emit         = 1'b1;
      ev_nxt       = EV_HANDED;
      who_id_nxt   = id_r[pick_r];
      who_pri_nxt  = prio_r[pick_r];
      held_out_nxt = held_r + 8'd1;
    end else if (ctl.do_expire) begin
      emit        = 1'b1;
      ev_nxt      = EV_TIMED_OUT;
      who_id_nxt  = id_r[idx_sel];
      who_pri_nxt = prio_r[idx_sel];
      last_nxt    = expire_last;
    end else begin
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      limit_r     <= LIMIT_RESET;
      held_r      <= 8'd0;
      fill_r      <= '0;
      idx_r       <= '0;
      nres_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CAP) begin
          cap_r <= cfg_wdata[7:0];
        end else begin
          limit_r <= cfg_wdata;
        end
      end

      priority if (ctl.do_arrive && grant) begin
        held_r <= held_r + 8'd1;
      end else if (ctl.do_leave && held_r != 8'd0) begin
        held_r <= held_dec;
      end else if (ctl.do_give) begin
        held_r <= held_r + 8'd1;
      end else begin
        held_r <= held_r;
      end

      priority if (append) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (remove) begin
        fill_r <= fill_r - CNT_W'(1);
      end else begin
        fill_r <= fill_r;
      end

      priority if (ctl.idx_clr) begin
        idx_r <= '0;
      end else if (ctl.idx_inc) begin
        idx_r <= idx_r + CNT_W'(1);
      end else begin
        idx_r <= idx_r;
      end

      priority if (ctl.idx_clr) begin
        nres_r <= 4'd0;
      end else if (ctl.do_expire) begin
        nres_r <= nres_r + 4'd1;
      end else begin
        nres_r <= nres_r;
      end

      priority if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r  <= cmd_t'(in_command);
      ipri_r <= in_is_priority;
      iid_r  <= in_requester_id;
    end
    if (ctl.pick_load) begin
      pick_r <= (in_range && prio_r[idx_sel]) ? idx_sel : '0;
    end
    if (emit) begin
      ev_r       <= ev_nxt;
      who_id_r   <= who_id_nxt;
      who_pri_r  <= who_pri_nxt;
      held_out_r <= held_out_nxt;
      last_r     <= last_nxt;
    end
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      priority if (remove && CNT_W'(i) >= rem_pos) begin
        prio_r[i] <= prio_up[i];
        id_r[i]   <= id_up[i];
        age_r[i]  <= age_up[i];
        exp_r[i]  <= exp_up[i];
      end else if (append && CNT_W'(i) == fill_r) begin
        prio_r[i] <= ipri_r;
        id_r[i]   <= iid_r;
        age_r[i]  <= 16'd0;
        exp_r[i]  <= 1'b0;
      end else if (ctl.do_age) begin
        age_r[i] <= age_inc[i];
        exp_r[i] <= (age_inc[i] >= lim_eff);
      end else begin
        age_r[i] <= age_r[i];
        exp_r[i] <= exp_r[i];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_who_id       = who_id_r;
  assign out_who_priority = who_pri_r;
  assign out_held_count   = held_out_r;
  assign out_last         = last_r;

endmodule

// ===== hw/rtl/priority_slot_semaphore.sv =====
// ---------------------------------------------------------------------------
// priority_slot_semaphore
// counting semaphore with a two-class, arrival-ordered wait list
// ---------------------------------------------------------------------------
// One beat is worked on at a time: in_ready drops after a beat is taken and
// rises once its last result has been loaded into the output register, or
// once its work ends when it gives no result. Arrive and leave without
// handover are latched and then executed. A leave that hands its slot
// over scans the wait entries one at a time to find the oldest priority
// waiter (at most WAIT_DEPTH entries) and then hands the slot over.
// A tick first ages all waiters, then steps past or expels one wait entry at
// a time, with a finishing step unless its final step expels the last
// expired waiter. The single output register lets the next result load in
// the cycle the present one is taken; out_ready held low stalls the
// sequencer. Configuration writes go straight to the registers and should
// be made while the block is idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_slot_semaphore
  import pss_pkg::*;
#(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic        in_is_priority,
  input  logic [7:0]  in_requester_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_who_id,
  output logic        out_who_priority,
  output logic [7:0]  out_held_count,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  pss_cmd_t ctl;
  pss_sts_t sts;
  logic     dp_active;
  logic     handed_beat;
  logic     empty_beat;
  logic     empty_ok;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  pss_dpath #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_command       (in_command),
    .in_is_priority   (in_is_priority),
    .in_requester_id  (in_requester_id),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_event_res    (out_event_res),
    .out_who_id       (out_who_id),
    .out_who_priority (out_who_priority),
    .out_held_count   (out_held_count),
    .out_last         (out_last)
  );

  assign dp_active   = ctl.do_give || ctl.do_expire || ctl.do_arrive || ctl.do_leave;
  assign handed_beat = out_valid && (out_event_res == EV_HANDED);
  assign empty_beat  = out_valid && (out_event_res == EV_LEAVE_EMPTY);
  assign empty_ok    = out_last && (out_who_id == 8'd0) && (out_held_count == 8'd0);

  // one beat in flight at a time
  `PSS_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
  // no list update or result while waiting for a new beat
  `PSS_ASSERT_IMP(a_idle_quiet, clk, rst_n, in_ready, !dp_active)
  // a handover always ends its leave
  `PSS_ASSERT_IMP(a_handed_last, clk, rst_n, handed_beat, out_last)
  // leave on an empty semaphore is a lone result with cleared tag
  `PSS_ASSERT_IMP(a_empty_leave, clk, rst_n, empty_beat, empty_ok)

endmodule
